[rtl/core/bhp_pkg.sv]
// Shared types, constants and helper functions of the hybrid branch predictor.
package bhp_pkg;

    // Default sizing
    localparam int MAX_INDEX_BITS = 12;
    localparam int ADDR_WIDTH     = 32;

    // Configuration port
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int CFG_W    = 4;
    localparam int COUNT_W  = 32;

    // Counter widths and values
    localparam int CTR_W = 3;
    localparam int CHS_W = 2;
    localparam logic [CTR_W-1:0] CTR_INIT    = 3'd4;
    localparam logic [CTR_W-1:0] CTR_MAX     = 3'd7;
    localparam logic [CTR_W-1:0] CTR_TAKEN   = 3'd4;
    localparam logic [CHS_W-1:0] CHS_INIT    = 2'd1;
    localparam logic [CHS_W-1:0] CHS_MAX     = 2'd3;
    localparam logic [CHS_W-1:0] CHS_GSHARE  = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] CHOOSER_BITS_RST = 4'd8;
    localparam logic [CFG_W-1:0] GSHARE_BITS_RST  = 4'd10;
    localparam logic [CFG_W-1:0] HIST_LEN_RST     = 4'd6;
    localparam logic [CFG_W-1:0] BIMODAL_BITS_RST = 4'd10;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_CHOOSER_BITS = 2'd0,
        REG_GSHARE_BITS  = 2'd1,
        REG_HIST_LEN     = 2'd2,
        REG_BIMODAL_BITS = 2'd3
    } reg_idx_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] chooser_bits;
        logic [CFG_W-1:0] gshare_bits;
        logic [CFG_W-1:0] hist_len;
        logic [CFG_W-1:0] bimodal_bits;
    } bhp_cfg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_UPDATE = 3'b100
    } bhp_state_t;

    // Saturating step of a 3-bit prediction counter
    function automatic logic [CTR_W-1:0] ctr_step(logic [CTR_W-1:0] c, logic up);
        logic [CTR_W-1:0] r;
        r = c;
        if (up && (c != CTR_MAX))
            r = c + 3'd1;
        else if (!up && (c != '0))
            r = c - 3'd1;
        return r;
    endfunction

    // Saturating step of a 2-bit chooser counter
    function automatic logic [CHS_W-1:0] chs_step(logic [CHS_W-1:0] c, logic up);
        logic [CHS_W-1:0] r;
        r = c;
        if (up && (c != CHS_MAX))
            r = c + 2'd1;
        else if (!up && (c != '0))
            r = c - 2'd1;
        return r;
    endfunction

endpackage

[rtl/core/bhp_if.sv]
// Branch and result channel interfaces of the hybrid branch predictor.
interface bhp_branch_if #(
    parameter int ADDR_WIDTH = bhp_pkg::ADDR_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] branch_address;
    logic                  taken;

    modport source (output valid, branch_address, taken, input ready);
    modport sink   (input valid, branch_address, taken, output ready);
endinterface

interface bhp_result_if ();
    logic                        valid;
    logic                        ready;
    logic                        predicted_taken;
    logic                        mispredicted;
    logic                        used_gshare;
    logic [bhp_pkg::COUNT_W-1:0] mispredict_total;

    modport source (output valid, predicted_taken, mispredicted, used_gshare,
                    mispredict_total, input ready);
    modport sink   (input valid, predicted_taken, mispredicted, used_gshare,
                    mispredict_total, output ready);
endinterface

[rtl/core/bhp_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module bhp_ram #(
    parameter int AW = bhp_pkg::MAX_INDEX_BITS,
    parameter int DW = bhp_pkg::CTR_W
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port, data held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/bhp_cfg_regs.sv]
// APB-style configuration registers of the hybrid branch predictor.
module bhp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bhp_pkg::PADDR_W-1:0]   paddr,
    input  logic [bhp_pkg::PDATA_W-1:0]   pwdata,
    output logic [bhp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output bhp_pkg::bhp_cfg_t             cfg
);

    bhp_pkg::bhp_cfg_t cfg_reg;
    bhp_pkg::bhp_cfg_t cfg_next;
    bhp_pkg::reg_idx_t idx;
    logic              wr_en;
    logic [bhp_pkg::CFG_W-1:0] wval;
    logic [bhp_pkg::CFG_W-1:0] rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = bhp_pkg::reg_idx_t'(paddr[3:2]);
    assign wval   = pwdata[bhp_pkg::CFG_W-1:0];

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                bhp_pkg::REG_CHOOSER_BITS: cfg_next.chooser_bits = wval;
                bhp_pkg::REG_GSHARE_BITS:  cfg_next.gshare_bits  = wval;
                bhp_pkg::REG_HIST_LEN:     cfg_next.hist_len     = wval;
                bhp_pkg::REG_BIMODAL_BITS: cfg_next.bimodal_bits = wval;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chooser_bits <= bhp_pkg::CHOOSER_BITS_RST;
            cfg_reg.gshare_bits  <= bhp_pkg::GSHARE_BITS_RST;
            cfg_reg.hist_len     <= bhp_pkg::HIST_LEN_RST;
            cfg_reg.bimodal_bits <= bhp_pkg::BIMODAL_BITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            bhp_pkg::REG_CHOOSER_BITS: rval = cfg_reg.chooser_bits;
            bhp_pkg::REG_GSHARE_BITS:  rval = cfg_reg.gshare_bits;
            bhp_pkg::REG_HIST_LEN:     rval = cfg_reg.hist_len;
            bhp_pkg::REG_BIMODAL_BITS: rval = cfg_reg.bimodal_bits;
            default:                   rval = '0;
        endcase
    end

    assign prdata = {{(bhp_pkg::PDATA_W - bhp_pkg::CFG_W){1'b0}}, rval};
    assign cfg    = cfg_reg;

endmodule

[rtl/core/bhp_core.sv]
// Predictor datapath: table lookup, counter update, history and miss count.
module bhp_core #(
    parameter int MAX_INDEX_BITS = bhp_pkg::MAX_INDEX_BITS,
    parameter int ADDR_WIDTH     = bhp_pkg::ADDR_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bhp_pkg::bhp_cfg_t  cfg,
    bhp_branch_if.sink         branch,
    bhp_result_if.source       result
);

    localparam int IW = MAX_INDEX_BITS;
    localparam int NW = ($clog2(IW + 1) > bhp_pkg::CFG_W) ? $clog2(IW + 1) : bhp_pkg::CFG_W;

    // Sequencer and control
    bhp_pkg::bhp_state_t state_reg, state_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic          clearing;
    logic          accept;
    logic          out_free;
    logic          commit;

    // Per-item registers (no reset, loaded at accept)
    logic [IW-1:0] gi_reg, bi_reg, ci_reg;
    logic          taken_reg;

    // Architectural state
    logic [IW-1:0]                history_reg, history_next;
    logic [bhp_pkg::COUNT_W-1:0]  miss_count_reg, miss_count_next;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic                         out_pred_reg, out_miss_reg, out_used_g_reg;
    logic [bhp_pkg::COUNT_W-1:0]  out_total_reg;

    // Index generation
    logic [IW-1:0] pc_bits;
    logic [IW-1:0] k_mask, m1_mask, m2_mask, hist_mask;
    logic [IW-1:0] hist_used;
    logic [IW-1:0] gi_calc, bi_calc, ci_calc;
    logic [NW-1:0] m1_ext, h_ext, k_ext, m2_ext, m1_eff, n_eff;

    // Table read data and update values
    logic [bhp_pkg::CTR_W-1:0] g_rd, b_rd, g_new, b_new;
    logic [bhp_pkg::CHS_W-1:0] c_rd, c_new;
    logic gpred, bpred, use_g, final_pred, miss;
    logic [IW-1:0] hist_ins;

    // Table write ports
    logic                      g_we, b_we, c_we;
    logic [IW-1:0]             g_waddr, b_waddr, c_waddr;
    logic [bhp_pkg::CTR_W-1:0] g_wdata, b_wdata;
    logic [bhp_pkg::CHS_W-1:0] c_wdata;

    // Address bits [IW+1:2], zero above the address width
    for (genvar i = 0; i < IW; i++)
    begin : g_pc
        if (i + 2 < ADDR_WIDTH)
        begin : g_in
            assign pc_bits[i] = branch.branch_address[i+2];
        end
        else
        begin : g_zero
            assign pc_bits[i] = 1'b0;
        end
    end

    // Effective widths: gshare width clamped, history clamped to it
    assign k_ext  = NW'(cfg.chooser_bits);
    assign m1_ext = NW'(cfg.gshare_bits);
    assign m2_ext = NW'(cfg.bimodal_bits);
    assign h_ext  = NW'(cfg.hist_len);
    assign m1_eff = (m1_ext > NW'(IW)) ? NW'(IW) : m1_ext;
    assign n_eff  = (h_ext > m1_eff) ? m1_eff : h_ext;

    // Low-bit masks; widths above the table size saturate naturally
    always_comb
    begin
        for (int i = 0; i < IW; i++)
        begin
            k_mask[i]    = NW'(i) < k_ext;
            m1_mask[i]   = NW'(i) < m1_eff;
            m2_mask[i]   = NW'(i) < m2_ext;
            hist_mask[i] = NW'(i) < n_eff;
            hist_ins[i]  = NW'(i + 1) == n_eff;
        end
    end

    assign hist_used = history_reg & hist_mask;
    assign gi_calc   = (pc_bits & m1_mask) ^ hist_used;
    assign bi_calc   = pc_bits & m2_mask;
    assign ci_calc   = pc_bits & k_mask;

    // Handshake
    assign branch.ready = (state_reg == bhp_pkg::S_IDLE);
    assign accept       = branch.valid && branch.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign commit       = (state_reg == bhp_pkg::S_UPDATE) && out_free;
    assign clearing     = (state_reg == bhp_pkg::S_CLEAR);

    // Prediction and counter updates from the read data
    always_comb
    begin
        gpred      = g_rd >= bhp_pkg::CTR_TAKEN;
        bpred      = b_rd >= bhp_pkg::CTR_TAKEN;
        use_g      = c_rd >= bhp_pkg::CHS_GSHARE;
        final_pred = use_g ? gpred : bpred;
        miss       = final_pred != taken_reg;
        g_new      = bhp_pkg::ctr_step(g_rd, taken_reg);
        b_new      = bhp_pkg::ctr_step(b_rd, taken_reg);
        c_new      = c_rd;
        if ((gpred == taken_reg) && (bpred != taken_reg))
            c_new = bhp_pkg::chs_step(c_rd, 1'b1);
        else if ((gpred != taken_reg) && (bpred == taken_reg))
            c_new = bhp_pkg::chs_step(c_rd, 1'b0);
    end

    // Table write muxing: clearing sweep or committed update
    always_comb
    begin
        g_we    = clearing || (commit && use_g);
        b_we    = clearing || (commit && !use_g);
        c_we    = clearing || commit;
        g_waddr = clearing ? clr_idx_reg : gi_reg;
        b_waddr = clearing ? clr_idx_reg : bi_reg;
        c_waddr = clearing ? clr_idx_reg : ci_reg;
        g_wdata = clearing ? bhp_pkg::CTR_INIT : g_new;
        b_wdata = clearing ? bhp_pkg::CTR_INIT : b_new;
        c_wdata = clearing ? bhp_pkg::CHS_INIT : c_new;
    end

    // Tables; a write at commit lands before the next item can be read
    bhp_ram #(.AW(IW), .DW(bhp_pkg::CTR_W)) u_gshare (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (accept),
        .raddr (gi_calc),
        .rdata (g_rd)
    );

    bhp_ram #(.AW(IW), .DW(bhp_pkg::CTR_W)) u_bimodal (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (accept),
        .raddr (bi_calc),
        .rdata (b_rd)
    );

    bhp_ram #(.AW(IW), .DW(bhp_pkg::CHS_W)) u_chooser (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (accept),
        .raddr (ci_calc),
        .rdata (c_rd)
    );

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            bhp_pkg::S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                    state_next = bhp_pkg::S_IDLE;
            end
            bhp_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = bhp_pkg::S_UPDATE;
            end
            bhp_pkg::S_UPDATE:
            begin
                if (out_free)
                    state_next = bhp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bhp_pkg::S_CLEAR;
            end
        endcase
    end

    // History, miss count and result valid
    always_comb
    begin
        history_next    = history_reg;
        miss_count_next = miss_count_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        if (commit)
        begin
            history_next   = (hist_used >> 1) | (taken_reg ? hist_ins : '0);
            out_valid_next = 1'b1;
            if (miss && (miss_count_reg != '1))
                miss_count_next = miss_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bhp_pkg::S_CLEAR;
            clr_idx_reg    <= '0;
            history_reg    <= '0;
            miss_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            history_reg    <= history_next;
            miss_count_reg <= miss_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gi_reg    <= gi_calc;
            bi_reg    <= bi_calc;
            ci_reg    <= ci_calc;
            taken_reg <= branch.taken;
        end
        if (commit)
        begin
            out_pred_reg   <= final_pred;
            out_miss_reg   <= miss;
            out_used_g_reg <= use_g;
            out_total_reg  <= miss_count_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.predicted_taken  = out_pred_reg;
    assign result.mispredicted     = out_miss_reg;
    assign result.used_gshare      = out_used_g_reg;
    assign result.mispredict_total = out_total_reg;

    // Checks
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> miss_count_reg >= $past(miss_count_reg))
        else $error("miss count decreased");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && miss) |=> (miss_count_reg == $past(miss_count_reg) + 1'b1) ||
                             ($past(miss_count_reg) == '1))
        else $error("miss count did not advance on a mispredict");

    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == bhp_pkg::S_UPDATE) && !branch.ready)
        else $error("accepted branch did not enter update");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && !commit) |=> out_valid_reg)
        else $error("pending result dropped");

    a_history_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (n_eff == '0)) |=> (history_reg == '0))
        else $error("history not cleared with zero length");

endmodule

[rtl/core/hybrid_branch_predictor_unit.sv]
// Top level of the hybrid (gshare plus bimodal) branch predictor.
//
// Usage: the branch channel delivers one resolved branch per beat (address and
// actual outcome); the result channel returns one beat per branch carrying the
// final prediction, the mispredict flag, which predictor was chosen and the
// saturating running mispredict total. Both channels use valid/ready.
// Configuration (index widths, history length) is written through the APB
// port at byte addresses 0, 4, 8 and 12 while the block is idle.
//
// Timing: the counter tables are read-modify-written: they are read when the
// branch beat is accepted, and the update step writes the counters back and loads
// the result register. No new branch is taken until the update step is done.
// A result waiting in the output register does not block the next accept;
// only a second result finding that register still full holds the block in
// its update step until the receiver takes the first one.
//
// Reset: history and mispredict total clear at once; the three tables are then
// swept to their initial values, all 2**MAX_INDEX_BITS entries (4096 by default),
// during which no branch is accepted. Registers can be written then.
module hybrid_branch_predictor_unit #(
    parameter int MAX_INDEX_BITS = bhp_pkg::MAX_INDEX_BITS,
    parameter int ADDR_WIDTH     = bhp_pkg::ADDR_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bhp_branch_if.sink                  branch,
    bhp_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhp_pkg::PADDR_W-1:0] paddr,
    input  logic [bhp_pkg::PDATA_W-1:0] pwdata,
    output logic [bhp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    bhp_pkg::bhp_cfg_t cfg;

    bhp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bhp_core #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .ADDR_WIDTH     (ADDR_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .branch (branch),
        .result (result)
    );

endmodule
